// ----- sv/lppo_pkg.sv -----
// ----------------------------------------------------------------------------
// lppo_pkg
// Shared types and constants for the lidar packet parser and obstacle unit.
// ----------------------------------------------------------------------------
package lppo_pkg;

  localparam int unsigned POINTS_PER_PACKET = 12;
  localparam int unsigned PT_IDX_W          = 4;

  localparam logic [7:0]  HDR0_BYTE   = 8'h54;
  localparam logic [7:0]  HDR1_BYTE   = 8'h2C;
  localparam logic [7:0]  CRC_INIT    = 8'hD8;
  localparam logic [7:0]  CRC_POLY    = 8'h4D;
  localparam logic [16:0] FULL_TURN   = 17'd36000;
  localparam logic [15:0] NONE_DIST   = 16'd9999;

  // Body byte positions
  localparam logic [5:0] IDX_SPEED_HI = 6'd1;
  localparam logic [5:0] IDX_START_HI = 6'd3;
  localparam logic [5:0] IDX_PT_FIRST = 6'd4;
  localparam logic [5:0] IDX_PT_LAST  = 6'd39;
  localparam logic [5:0] IDX_END_HI   = 6'd41;
  localparam logic [5:0] IDX_STAMP_HI = 6'd43;
  localparam logic [5:0] IDX_CRC      = 6'd44;

  // Divide by (POINTS_PER_PACKET - 1) = 11: ceil(2^19 / 11), exact below 36000
  localparam logic [15:0] RECIP_11    = 16'd47663;
  localparam int unsigned RECIP_SHIFT = 19;

  // Configuration register indexes
  localparam logic [2:0] CFG_ZONE_START = 3'd0;
  localparam logic [2:0] CFG_ZONE_END   = 3'd1;
  localparam logic [2:0] CFG_BRAKE      = 3'd2;
  localparam logic [2:0] CFG_MIN_VALID  = 3'd3;

  localparam logic [15:0] RST_ZONE_START = 16'd31500;
  localparam logic [15:0] RST_ZONE_END   = 16'd4500;
  localparam logic [15:0] RST_BRAKE      = 16'd600;
  localparam logic [15:0] RST_MIN_VALID  = 16'd50;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2
  } sync_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_CRC  = 3'd1,
    ST_MOD  = 3'd2,
    ST_DIFF = 3'd3,
    ST_MUL  = 3'd4,
    ST_EMIT = 3'd5
  } seq_state_t;

endpackage

// ----- sv/lidar_packet_parser_obstacle_unit.sv -----
// ----------------------------------------------------------------------------
// lidar_packet_parser_obstacle_unit
// Serial packet parser with CRC-8 check, angle interpolation and a front-zone
// obstacle verdict per packet.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+---------------------------------
//  in_      | in  | in_tvalid / in_tready  | in_tdata: rx_byte
//  out_     | out | out_tvalid / out_tready| out_tdata: point fields, out_tlast
//  cfg_     | in  | cfg_wr_en              | cfg_index, cfg_wdata
//
//  Header and hunting bytes need only the transfer. Body bytes take the
//  transfer plus 4 passes of the shared 2-bit CRC shifter. The CRC byte of a
//  good packet takes the transfer, angle setup (modulo, span, reciprocal
//  multiply) and emission of the 12 points, which out_tready can stall; a
//  failing CRC byte takes only the transfer. The output register
//  lets the next byte transfer in while the last point waits. rst_n is
//  synchronous; it clears the phase, sequencer and configuration registers,
//  while packet fields need no reset.
// ----------------------------------------------------------------------------
module lidar_packet_parser_obstacle_unit
  import lppo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [3:0] point_index, [19:4] distance_mm, [27:20] intensity,
  //   [43:28] angle, [44] in_zone, [60:45] rotation_speed, [76:61] time_stamp,
  //   [77] obstacle, [93:78] nearest_distance, [95:94] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [PT_IDX_W-1:0] LAST_PT = PT_IDX_W'(POINTS_PER_PACKET - 1);

  function automatic logic [7:0] crc_bit(input logic [7:0] c);
    logic [7:0] sh;
    sh = {c[6:0], 1'b0};
    return c[7] ? (sh ^ CRC_POLY) : sh;
  endfunction

  // configuration
  logic [15:0] zone_start_r, zone_end_r, brake_r, min_valid_r;

  // parser state
  sync_phase_t phase_r;
  logic [5:0]  idx_r;
  logic [7:0]  crc_r;
  logic [7:0]  hold_r;
  logic [15:0] speed_r, start_r, end_r, stamp_r;
  logic [PT_IDX_W-1:0] wr_pt_r;
  logic [1:0]  wr_sub_r;
  logic [15:0] dist_mem [POINTS_PER_PACKET];
  logic [7:0]  inten_mem [POINTS_PER_PACKET];

  // sequencer
  seq_state_t  state_r, state_nxt;
  logic [1:0]  crc_cnt_r;
  logic [15:0] s_mod_r, e_mod_r, diff_r;
  logic [11:0] step_r;
  logic [15:0] ang_r;
  logic [PT_IDX_W-1:0] emit_idx_r;
  logic        found_r;
  logic [15:0] nearest_r;

  // output register
  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_last_r;

  logic        in_xfer;
  logic        load_out;
  logic [7:0]  b;
  logic [15:0] word;
  logic        body_byte;
  logic        crc_ok;

  assign b         = in_tdata;
  assign word      = {b, hold_r};
  assign in_xfer   = in_tvalid && in_tready;
  assign body_byte = in_xfer && (phase_r == PH_BODY);
  assign crc_ok    = (crc_r == b);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (body_byte) begin
          if (idx_r < IDX_CRC) begin
            state_nxt = ST_CRC;
          end else if (crc_ok) begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_CRC:  if (crc_cnt_r == 2'd3) state_nxt = ST_IDLE;
      ST_MOD:  state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EMIT;
      ST_EMIT: if (load_out && emit_idx_r == LAST_PT) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EMIT: load_out  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // current point evaluation
  logic [15:0] cur_dist;
  logic [7:0]  cur_inten;
  logic        cur_zone, cur_qual, cur_last;
  logic        found_now;
  logic [15:0] nearest_now;
  logic [16:0] ang_sum;

  assign cur_dist  = dist_mem[emit_idx_r];
  assign cur_inten = inten_mem[emit_idx_r];
  assign cur_zone  = (ang_r >= zone_start_r) || (ang_r <= zone_end_r);
  assign cur_qual  = cur_zone && (cur_dist > min_valid_r) && (cur_dist < brake_r);
  assign cur_last  = (emit_idx_r == LAST_PT);
  assign found_now = found_r || cur_qual;
  assign nearest_now = (cur_qual && cur_dist < nearest_r) ? cur_dist : nearest_r;
  assign ang_sum   = {1'b0, ang_r} + {5'd0, step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_start_r <= RST_ZONE_START;
      zone_end_r   <= RST_ZONE_END;
      brake_r      <= RST_BRAKE;
      min_valid_r  <= RST_MIN_VALID;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ZONE_START: zone_start_r <= cfg_wdata;
        CFG_ZONE_END:   zone_end_r   <= cfg_wdata;
        CFG_BRAKE:      brake_r      <= cfg_wdata;
        CFG_MIN_VALID:  min_valid_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HUNT;
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      crc_cnt_r   <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
      wr_pt_r     <= '0;
      wr_sub_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (in_xfer) begin
        unique case (phase_r)
          PH_HDR: begin
            if (b == HDR1_BYTE) begin
              phase_r <= PH_BODY;
              idx_r   <= '0;
              crc_r   <= CRC_INIT;
            end else if (b != HDR0_BYTE) begin
              phase_r <= PH_HUNT;
            end
          end
          PH_BODY: begin
            if (idx_r < IDX_CRC) begin
              crc_r     <= crc_r ^ b;
              crc_cnt_r <= '0;
              idx_r     <= idx_r + 6'd1;
            end else begin
              phase_r <= PH_HUNT;
              idx_r   <= '0;
            end
            if (idx_r == IDX_START_HI) begin
              wr_pt_r  <= '0;
              wr_sub_r <= '0;
            end else if (idx_r >= IDX_PT_FIRST && idx_r <= IDX_PT_LAST) begin
              if (wr_sub_r == 2'd2) begin
                wr_sub_r <= '0;
                wr_pt_r  <= wr_pt_r + PT_IDX_W'(1);
              end else begin
                wr_sub_r <= wr_sub_r + 2'd1;
              end
            end
          end
          default: phase_r <= (b == HDR0_BYTE) ? PH_HDR : PH_HUNT;
        endcase
      end

      // two CRC bits per pass through the shared shifter
      if (state_r == ST_CRC) begin
        crc_r     <= crc_bit(crc_bit(crc_r));
        crc_cnt_r <= crc_cnt_r + 2'd1;
      end

      if (state_r == ST_MUL) begin
        emit_idx_r <= '0;
      end else if (load_out) begin
        emit_idx_r <= emit_idx_r + PT_IDX_W'(1);
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // packet fields and point store
  always_ff @(posedge clk) begin
    if (body_byte && idx_r < IDX_CRC) begin
      hold_r <= b;
      if (idx_r == IDX_SPEED_HI) speed_r <= word;
      if (idx_r == IDX_START_HI) start_r <= word;
      if (idx_r == IDX_END_HI)   end_r   <= word;
      if (idx_r == IDX_STAMP_HI) stamp_r <= word;
      if (idx_r >= IDX_PT_FIRST && idx_r <= IDX_PT_LAST) begin
        if (wr_sub_r == 2'd1) begin
          dist_mem[wr_pt_r] <= word;
        end
        if (wr_sub_r == 2'd2) begin
          inten_mem[wr_pt_r] <= b;
        end
      end
    end
  end

  // angle setup and emission datapath
  always_ff @(posedge clk) begin
    logic [31:0] prod;
    prod = {16'd0, diff_r} * {16'd0, RECIP_11};
    unique case (state_r)
      ST_MOD: begin
        s_mod_r <= ({1'b0, start_r} >= FULL_TURN) ?
                   16'({1'b0, start_r} - FULL_TURN) : start_r;
        e_mod_r <= ({1'b0, end_r} >= FULL_TURN) ?
                   16'({1'b0, end_r} - FULL_TURN) : end_r;
      end
      ST_DIFF: begin
        diff_r <= (e_mod_r >= s_mod_r) ? (e_mod_r - s_mod_r) :
                  16'({1'b0, e_mod_r} + FULL_TURN - {1'b0, s_mod_r});
      end
      ST_MUL: begin
        step_r    <= prod[RECIP_SHIFT +: 12];
        ang_r     <= s_mod_r;
        found_r   <= 1'b0;
        nearest_r <= NONE_DIST;
      end
      ST_EMIT: begin
        if (load_out) begin
          ang_r     <= (ang_sum >= FULL_TURN) ? 16'(ang_sum - FULL_TURN) : ang_sum[15:0];
          found_r   <= found_now;
          nearest_r <= nearest_now;
          out_last_r <= cur_last;
          out_data_r <= {2'b00,
                         cur_last ? nearest_now : 16'd0,
                         cur_last && found_now,
                         stamp_r,
                         speed_r,
                         cur_zone,
                         ang_r,
                         cur_inten,
                         cur_dist,
                         emit_idx_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_last_is_point11: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == LAST_PT)
    else $error("tlast on a point other than the last");

  a_verdict_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[77] && out_tdata[93:78] == 16'd0)
    else $error("obstacle verdict on a non-final point");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !in_tready)
    else $error("input accepted during emission");

  a_emit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> emit_idx_r <= LAST_PT)
    else $error("emission index out of range");

endmodule

// ----- tb/tb_lidar_packet_parser_obstacle_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lidar_packet_parser_obstacle_unit
// Self-checking bench for the lidar packet parser: sends serial packets
// (clean, repeated or false headers, bad CRC, noise) through the byte stream,
// predicts the 12 emitted points per good packet and checks them in order,
// over several zone, brake and minimum-distance settings.
// ----------------------------------------------------------------------------
module tb_lidar_packet_parser_obstacle_unit;
  import lppo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BODY_BYTES   = 45;
  localparam int unsigned CRC_SPAN     = 44;
  localparam int unsigned TURN         = 36000;
  localparam int unsigned LAST_POINT   = POINTS_PER_PACKET - 1;
  localparam int unsigned ITEM_TARGET  = 420;
  localparam int unsigned SEQ_PER_SET  = 1;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned MAX_REPORTS  = 60;
  localparam int unsigned DIR_ROWS     = 7;
  localparam logic [2:0]  CFG_SPARE_FIRST = 3'd4;
  localparam logic [2:0]  CFG_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {
    PRE_PLAIN      = 2'd0,
    PRE_DOUBLE_HDR = 2'd1,
    PRE_FALSE_HDR  = 2'd2
  } prefix_t;

  typedef enum logic {
    DM_FIXED  = 1'b0,
    DM_RANDOM = 1'b1
  } dist_mode_t;

  // Field order matches out_tdata from the top bit down
  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] nearest;
    logic        obstacle;
    logic [15:0] stamp;
    logic [15:0] speed;
    logic        in_zone;
    logic [15:0] angle;
    logic [7:0]  inten;
    logic [15:0] dist_mm;
    logic [3:0]  idx;
  } point_t;

  typedef struct packed {
    point_t f;
    logic   last;
  } point_exp_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
    logic [15:0] stamp;
    logic [POINTS_PER_PACKET-1:0][15:0] dist_mm;
    logic [POINTS_PER_PACKET-1:0][7:0]  inten;
    logic        bad_crc;
  } pkt_t;

  typedef struct packed {
    prefix_t     pre;
    logic [15:0] speed;
    logic [15:0] start_ang;
    logic [15:0] end_ang;
    logic [15:0] stamp;
    dist_mode_t  dmode;
    logic [15:0] dist_mm;
    logic [7:0]  inten;
    logic        bad_crc;
    logic        typed;
    logic        exp_emit;
    logic        exp_obst;
    logic [15:0] exp_near;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  lidar_packet_parser_obstacle_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Configuration mirror
  logic [15:0] zone_start_cfg, zone_end_cfg, brake_cfg, min_valid_cfg;

  // Parser mirror
  sync_phase_t parse_phase;
  logic [5:0]  body_pos;
  logic [7:0]  crc_run;
  logic [7:0]  held_byte;
  logic [15:0] pkt_speed, pkt_start, pkt_end, pkt_stamp;
  logic [23:0] pkt_points [POINTS_PER_PACKET];

  point_exp_t  exp_points [$];

  int unsigned n_fail = 0;
  int unsigned n_points = 0;
  int unsigned n_pkts = 0;
  int unsigned n_bytes = 0;
  int unsigned n_settings = 0;
  logic        seen_obst;
  logic [15:0] seen_near;
  bit          in_burst = 1'b0;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    int k;
    v = c ^ b;
    for (k = 0; k < 8; k++)
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    return v;
  endfunction

  task automatic emit_points();
    int unsigned s, e, step, ang, i;
    logic        found;
    logic [15:0] near, d;
    logic        zone, is_last;
    point_exp_t  x;
    s = int'(pkt_start) % TURN;
    e = int'(pkt_end) % TURN;
    step = ((e + TURN - s) % TURN) / LAST_POINT;
    found = 1'b0;
    near = NONE_DIST;
    for (i = 0; i < POINTS_PER_PACKET; i++) begin
      d = pkt_points[i][23:8];
      ang = (s + step * i) % TURN;
      zone = (ang >= zone_start_cfg) || (ang <= zone_end_cfg);
      is_last = (i == LAST_POINT);
      if (zone && d > min_valid_cfg && d < brake_cfg) begin
        found = 1'b1;
        if (d < near) near = d;
      end
      x = '0;
      x.f.idx = 4'(i);
      x.f.dist_mm = d;
      x.f.inten = pkt_points[i][7:0];
      x.f.angle = 16'(ang);
      x.f.in_zone = zone;
      x.f.speed = pkt_speed;
      x.f.stamp = pkt_stamp;
      x.f.obstacle = is_last && found;
      x.f.nearest = is_last ? near : 16'd0;
      x.last = is_last;
      exp_points = {exp_points, x};
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] word;
    int unsigned k, r;
    word = {b, held_byte};
    if (parse_phase == PH_HDR) begin
      if (b == HDR1_BYTE) begin
        parse_phase = PH_BODY;
        body_pos = '0;
        crc_run = CRC_INIT;
      end else if (b != HDR0_BYTE) begin
        parse_phase = PH_HUNT;
      end
    end else if (parse_phase != PH_BODY) begin
      parse_phase = (b == HDR0_BYTE) ? PH_HDR : PH_HUNT;
    end else if (body_pos >= IDX_CRC) begin
      // CRC byte: always resync, emit only on a match
      parse_phase = PH_HUNT;
      body_pos = '0;
      if (crc_run == b) emit_points();
    end else begin
      crc_run = crc8_step(crc_run, b);
      if (body_pos == IDX_SPEED_HI) pkt_speed = word;
      else if (body_pos == IDX_START_HI) pkt_start = word;
      else if (body_pos >= IDX_PT_FIRST && body_pos <= IDX_PT_LAST) begin
        k = (body_pos - IDX_PT_FIRST) / 3;
        r = (body_pos - IDX_PT_FIRST) % 3;
        if (r == 1) pkt_points[k] = {word, 8'h00};
        else if (r == 2) pkt_points[k][7:0] = b;
      end
      else if (body_pos == IDX_END_HI) pkt_end = word;
      else if (body_pos == IDX_STAMP_HI) pkt_stamp = word;
      held_byte = b;
      body_pos = body_pos + 6'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: point %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_point(input logic [95:0] data, input logic last);
    point_t     act;
    point_exp_t x;
    act = point_t'(data);
    if (exp_points.size() == 0) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: unexpected point, expected none, got index %0d distance %0d",
                 $time, act.idx, act.dist_mm);
      return;
    end
    x = exp_points.pop_front();
    check_field("index", 16'(x.f.idx), 16'(act.idx));
    check_field("distance", x.f.dist_mm, act.dist_mm);
    check_field("intensity", 16'(x.f.inten), 16'(act.inten));
    check_field("angle", x.f.angle, act.angle);
    check_field("in_zone", 16'(x.f.in_zone), 16'(act.in_zone));
    check_field("rotation_speed", x.f.speed, act.speed);
    check_field("time_stamp", x.f.stamp, act.stamp);
    check_field("obstacle", 16'(x.f.obstacle), 16'(act.obstacle));
    check_field("nearest", x.f.nearest, act.nearest);
    check_field("pad", 16'(x.f.pad), 16'(act.pad));
    check_field("tlast", 16'(x.last), 16'(last));
    n_points++;
    if (last) begin
      n_pkts++;
      seen_obst = act.obstacle;
      seen_near = act.nearest;
    end
  endtask

  // Monitor: outputs first, then config and input transfers of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      zone_start_cfg <= RST_ZONE_START;
      zone_end_cfg   <= RST_ZONE_END;
      brake_cfg      <= RST_BRAKE;
      min_valid_cfg  <= RST_MIN_VALID;
      parse_phase = PH_HUNT;
      body_pos = '0;
      crc_run = CRC_INIT;
    end else begin
      if (out_tvalid && out_tready) check_point(out_tdata, out_tlast);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ZONE_START: zone_start_cfg <= cfg_wdata;
          CFG_ZONE_END:   zone_end_cfg   <= cfg_wdata;
          CFG_BRAKE:      brake_cfg      <= cfg_wdata;
          CFG_MIN_VALID:  min_valid_cfg  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata);
    end
  end

  // Receiver back-pressure: free-running spans, short and long stalls
  int unsigned ready_hold = 0;
  int unsigned ready_free = 0;
  int unsigned ready_roll;
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else if (ready_free > 0) begin
      out_tready <= 1'b1;
      ready_free = ready_free - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 3) begin
        ready_free = $urandom_range(50, 300);
        out_tready <= 1'b1;
      end else if (ready_roll < 70) begin
        out_tready <= 1'b1;
      end else if (ready_roll < 95) begin
        ready_hold = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        ready_hold = $urandom_range(9, 39);
        out_tready <= 1'b0;
      end
    end
  end

  function automatic int unsigned in_gap();
    int unsigned r;
    if (in_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold valid across back-to-back bytes; drop it only for a gap
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_bytes++;
    gap = in_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet(input pkt_t p, input prefix_t pre);
    logic [7:0] body [BODY_BYTES];
    logic [7:0] crc, junk;
    int unsigned i, k;
    body[0] = p.speed[7:0];
    body[1] = p.speed[15:8];
    body[2] = p.start_ang[7:0];
    body[3] = p.start_ang[15:8];
    for (k = 0; k < POINTS_PER_PACKET; k++) begin
      body[IDX_PT_FIRST + 3*k]     = p.dist_mm[k][7:0];
      body[IDX_PT_FIRST + 3*k + 1] = p.dist_mm[k][15:8];
      body[IDX_PT_FIRST + 3*k + 2] = p.inten[k];
    end
    body[40] = p.end_ang[7:0];
    body[41] = p.end_ang[15:8];
    body[42] = p.stamp[7:0];
    body[43] = p.stamp[15:8];
    crc = CRC_INIT;
    for (i = 0; i < CRC_SPAN; i++) crc = crc8_step(crc, body[i]);
    body[IDX_CRC] = p.bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
    if (pre == PRE_DOUBLE_HDR) begin
      send_byte(HDR0_BYTE);
      send_byte(HDR0_BYTE);
    end else if (pre == PRE_FALSE_HDR) begin
      junk = 8'($urandom);
      if (junk == HDR0_BYTE || junk == HDR1_BYTE) junk = ~junk;
      send_byte(HDR0_BYTE);
      send_byte(junk);
    end
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    for (i = 0; i < BODY_BYTES; i++) send_byte(body[i]);
  endtask

  // Wait out all expected points, then the block's own processing
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned set_no);
    logic [15:0] zs, ze, brk, mnv;
    case (set_no)
      0: begin zs = 16'd0;     ze = 16'd0;     brk = 16'hFFFF; mnv = 16'd0;    end
      1: begin zs = 16'd35999; ze = 16'd35999; brk = 16'd0;    mnv = 16'hFFFF; end
      2: begin zs = 16'd35999; ze = 16'd0;     brk = 16'd1000; mnv = 16'd0;    end
      3: begin zs = 16'd9000;  ze = 16'd27000; brk = 16'd2000; mnv = 16'd100;  end
      default: begin
        zs = 16'($urandom_range(0, 35999));
        ze = 16'($urandom_range(0, 35999));
        brk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(100, 1500));
        mnv = 16'($urandom_range(0, 200));
      end
    endcase
    cfg_write(CFG_ZONE_START, zs);
    cfg_write(CFG_ZONE_END, ze);
    cfg_write(CFG_BRAKE, brk);
    cfg_write(CFG_MIN_VALID, mnv);
    if ($urandom_range(0, 1) == 0)
      cfg_write(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 16'($urandom));
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return brake_cfg + 16'($urandom_range(0, 6)) - 16'd3;
      2: return min_valid_cfg + 16'($urandom_range(0, 6)) - 16'd3;
      3: return 16'($urandom_range(0, 12000));
      default: return 16'($urandom_range(0, 1500));
    endcase
  endfunction

  function automatic pkt_t random_packet(input logic bad);
    pkt_t p;
    int unsigned k;
    p.speed = 16'($urandom);
    p.stamp = 16'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        p.start_ang = 16'($urandom);
        p.end_ang = 16'($urandom);
      end
      1: begin
        p.start_ang = 16'($urandom_range(0, 35999));
        p.end_ang = 16'((int'(p.start_ang) + $urandom_range(0, 1200)) % TURN);
      end
      2: begin
        p.start_ang = 16'($urandom_range(0, 35999));
        p.end_ang = 16'($urandom_range(0, 35999));
      end
      default: begin
        p.start_ang = 16'($urandom_range(35000, 35999));
        p.end_ang = 16'($urandom_range(0, 1000));
      end
    endcase
    for (k = 0; k < POINTS_PER_PACKET; k++) begin
      p.dist_mm[k] = pick_distance();
      p.inten[k] = 8'($urandom);
    end
    p.bad_crc = bad;
    return p;
  endfunction

  task automatic random_sequence();
    int unsigned r, k, len;
    prefix_t pre;
    in_burst = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 85) begin
      case ($urandom_range(0, 7))
        0: pre = PRE_DOUBLE_HDR;
        1: pre = PRE_FALSE_HDR;
        default: pre = PRE_PLAIN;
      endcase
      send_packet(random_packet(r >= 70), pre);
    end else begin
      len = $urandom_range(1, 20);
      for (k = 0; k < len; k++)
        send_byte(($urandom_range(0, 3) == 0) ? HDR0_BYTE : 8'($urandom));
    end
  endtask

  dir_row_t dir_tbl [DIR_ROWS];

  initial begin
    pkt_t        p;
    int unsigned row, k, pkts_before, set_no;
    dir_row_t    d;

    // pre, speed, start, end, stamp, distance mode, distance, inten, bad crc,
    // typed, emits, obstacle, nearest
    dir_tbl = '{
      '{PRE_PLAIN, 16'h0000, 16'd0, 16'd0, 16'h0000, DM_FIXED, 16'd0, 8'h00,
        1'b0, 1'b1, 1'b1, 1'b0, 16'd9999},
      '{PRE_PLAIN, 16'h1234, 16'd0, 16'd0, 16'h5678, DM_FIXED, 16'd300, 8'h80,
        1'b1, 1'b1, 1'b0, 1'b0, 16'd0},
      '{PRE_PLAIN, 16'h0003, 16'd0, 16'd0, 16'h0004, DM_FIXED, 16'd51, 8'h22,
        1'b0, 1'b1, 1'b1, 1'b1, 16'd51},
      '{PRE_PLAIN, 16'h0005, 16'd0, 16'd0, 16'h0006, DM_FIXED, 16'd600, 8'h33,
        1'b0, 1'b1, 1'b1, 1'b0, 16'd9999},
      '{PRE_PLAIN, 16'h0007, 16'd0, 16'd0, 16'h0008, DM_FIXED, 16'd599, 8'h44,
        1'b0, 1'b1, 1'b1, 1'b1, 16'd599},
      '{PRE_DOUBLE_HDR, 16'hA5A5, 16'd35999, 16'd0, 16'h5A5A, DM_RANDOM, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{PRE_FALSE_HDR, 16'h8001, 16'hFFFF, 16'hFFFF, 16'h7FFE, DM_RANDOM, 16'd0, 8'h00,
        1'b0, 1'b0, 1'b0, 1'b0, 16'd0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets at reset settings, each one drained before the next
    for (row = 0; row < DIR_ROWS; row++) begin
      d = dir_tbl[row];
      p.speed = d.speed;
      p.start_ang = d.start_ang;
      p.end_ang = d.end_ang;
      p.stamp = d.stamp;
      p.bad_crc = d.bad_crc;
      for (k = 0; k < POINTS_PER_PACKET; k++) begin
        p.dist_mm[k] = (d.dmode == DM_FIXED) ? d.dist_mm : pick_distance();
        p.inten[k] = (d.dmode == DM_FIXED) ? d.inten : 8'($urandom);
      end
      in_burst = (row % 4 == 3);
      pkts_before = n_pkts;
      send_packet(p, d.pre);
      drain();
      if (d.typed) begin
        if ((n_pkts - pkts_before) != int'(d.exp_emit)) begin
          n_fail++;
          $display("%0t: row %0d packets emitted mismatch, expected %0d, got %0d",
                   $time, row, d.exp_emit, n_pkts - pkts_before);
        end else if (d.exp_emit && (seen_obst !== d.exp_obst || seen_near !== d.exp_near)) begin
          n_fail++;
          $display("%0t: row %0d verdict mismatch, expected %0d/%0d, got %0d/%0d",
                   $time, row, d.exp_obst, d.exp_near, seen_obst, seen_near);
        end
      end
    end

    // Random sequences, a new setting after each idle point
    set_no = 0;
    while (n_bytes < ITEM_TARGET) begin
      apply_setting(set_no);
      set_no++;
      repeat (SEQ_PER_SET) random_sequence();
      drain();
    end

    if (exp_points.size() != 0) begin
      n_fail++;
      $display("%0t: points left over, expected 0, got %0d", $time, exp_points.size());
    end
    $display("Sent %0d bytes under %0d register settings plus reset values",
             n_bytes, n_settings);
    $display("Checked %0d points from %0d good packets", n_points, n_pkts);
    if (n_fail == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d points outstanding", $time, exp_points.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
